>>> hdl/ovc_pkg.sv
// Oven controller package: codes, reset values and controller/datapath types.
// No dependencies; ovc_ctrl, ovc_datapath and oven_controller_fsm import it.
package ovc_pkg;

  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 3;

  localparam logic [1:0] CMD_KNOB   = 2'd0;
  localparam logic [1:0] CMD_BUTTON = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] PH_SETUP  = 2'd0;
  localparam logic [1:0] PH_SELECT = 2'd1;
  localparam logic [1:0] PH_COOK   = 2'd2;
  localparam logic [1:0] PH_RESET  = 2'd3;

  localparam logic [1:0] MODE_BAKE  = 2'd0;
  localparam logic [1:0] MODE_BROIL = 2'd1;
  localparam logic [1:0] MODE_TOAST = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_HOLD_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TPS        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TEMP_BASE  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BAKE_TEMP  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BROIL_TEMP = 3'd4;

  localparam logic [15:0] HOLD_LIMIT_RST = 16'd5;
  localparam logic [7:0]  TPS_RST        = 8'd5;
  localparam logic [9:0]  TEMP_BASE_RST  = 10'd300;
  localparam logic [9:0]  BAKE_TEMP_RST  = 10'd350;
  localparam logic [9:0]  BROIL_TEMP_RST = 10'd500;

  localparam logic [7:0] LEDS_FULL = 8'hFF;
  localparam int         BAR_SHIFT = 3;   // eight bar segments
  localparam logic [3:0] MOD_TOP_BIT = 4'd8;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mod_step;
    logic led_apply;
    logic out_load;
  } ovc_ctl_t;

  typedef struct packed {
    logic need_mod;
    logic mod_last;
    logic out_free;
  } ovc_sts_t;

endpackage

>>> hdl/ovc_if.sv
// Handshake channel interfaces for oven events and oven status beats.
// Depends on nothing.
interface ovc_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [9:0] knob_value;
  logic       select_pressed;
  logic       select_released;
  logic       start_pressed;
  logic       start_released;
  modport source (output valid, cmd, knob_value, select_pressed, select_released,
                  start_pressed, start_released, input ready);
  modport sink (input valid, cmd, knob_value, select_pressed, select_released,
                start_pressed, start_released, output ready);
endinterface

interface ovc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic [1:0]  cook_mode;
  logic        adjust_temp;
  logic [8:0]  set_time;
  logic [8:0]  remaining;
  logic [10:0] temperature;
  logic [7:0]  led_bar;
  modport source (output valid, phase, cook_mode, adjust_temp, set_time, remaining,
                  temperature, led_bar, input ready);
  modport sink (input valid, phase, cook_mode, adjust_temp, set_time, remaining,
                temperature, led_bar, output ready);
endinterface

>>> hdl/ovc_ctrl.sv
// Oven controller sequencer: accept, execute, bar-segment remainder, deliver.
// Depends on ovc_pkg.
module ovc_ctrl
  import ovc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ovc_sts_t sts,
  output ovc_ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (!sts.need_mod) begin
          state_nxt = S_DONE;
        end else begin
          ctl.mod_step = 1'b1;
          if (sts.mod_last) begin
            ctl.led_apply = 1'b1;
            state_nxt     = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/ovc_datapath.sv
// Oven controller datapath: config registers, oven state, remainder unit
// and output register. Depends on ovc_pkg.
module ovc_datapath
  import ovc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [1:0]          in_cmd,
  input  logic [9:0]          in_knob_value,
  input  logic                in_select_pressed,
  input  logic                in_select_released,
  input  logic                in_start_pressed,
  input  logic                in_start_released,
  input  ovc_ctl_t            ctl,
  output ovc_sts_t            sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_phase,
  output logic [1:0]          out_cook_mode,
  output logic                out_adjust_temp,
  output logic [8:0]          out_set_time,
  output logic [8:0]          out_remaining,
  output logic [10:0]         out_temperature,
  output logic [7:0]          out_led_bar
);

  logic [15:0] hold_limit_r;
  logic [7:0]  tps_r;
  logic [9:0]  temp_base_r, bake_temp_r, broil_temp_r;

  logic [1:0] cmd_r;
  logic [9:0] knob_r;
  logic       sdn_r, sup_r, stdn_r, stup_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        adjust_r, adjust_nxt;
  logic [8:0]  time_r, time_nxt;
  logic [8:0]  remain_r, remain_nxt;
  logic [10:0] temp_r, temp_nxt;
  logic [8:0]  elapsed_r, elapsed_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] stamp_r, stamp_nxt;
  logic [7:0]  subtick_r, subtick_nxt;
  logic [7:0]  leds_r, leds_nxt;
  logic        need_mod_r, need_mod_nxt;

  logic [3:0] bit_idx_r;
  logic [5:0] rem_r;
  logic [5:0] div_eff, trial, rem_step;

  logic        out_valid_r;
  logic [1:0]  out_phase_r, out_mode_r;
  logic        out_adjust_r;
  logic [8:0]  out_time_r, out_remain_r;
  logic [10:0] out_temp_r;
  logic [7:0]  out_leds_r;

  logic [15:0] press_len;
  logic        press_is_long;
  logic [7:0]  knob_step;
  logic [7:0]  tps_eff, sub_inc;
  logic [8:0]  elapsed_inc;

  assign press_len     = tick_r - stamp_r;
  assign press_is_long = (press_len >= hold_limit_r);
  assign knob_step     = knob_r[9:2];
  assign tps_eff       = (tps_r == 8'd0) ? 8'd1 : tps_r;
  assign sub_inc       = subtick_r + 8'd1;
  assign elapsed_inc   = elapsed_r + 9'd1;

  // remainder of remaining by max(set_time/8, 1), one dividend bit per step
  assign div_eff  = (time_r[8:BAR_SHIFT] == 6'd0) ? 6'd1 : time_r[8:BAR_SHIFT];
  assign trial    = {rem_r[4:0], remain_r[bit_idx_r]};
  assign rem_step = (trial >= div_eff) ? (trial - div_eff) : trial;

  always_comb begin
    phase_nxt    = phase_r;
    mode_nxt     = mode_r;
    adjust_nxt   = adjust_r;
    time_nxt     = time_r;
    remain_nxt   = remain_r;
    temp_nxt     = temp_r;
    elapsed_nxt  = elapsed_r;
    tick_nxt     = tick_r;
    stamp_nxt    = stamp_r;
    subtick_nxt  = subtick_r;
    leds_nxt     = leds_r;
    need_mod_nxt = need_mod_r;
    if (ctl.exec) begin
      need_mod_nxt = 1'b0;
      case (cmd_r)
        CMD_KNOB: begin
          if (phase_r == PH_SETUP) begin
            case (mode_r)
              MODE_BAKE: begin
                if (adjust_r) begin
                  temp_nxt = {3'b000, knob_step} + {1'b0, temp_base_r};
                end else begin
                  time_nxt = {1'b0, knob_step} + 9'd1;
                end
              end
              MODE_BROIL: begin
                time_nxt = {1'b0, knob_step} + 9'd1;
                temp_nxt = {1'b0, broil_temp_r};
              end
              default: time_nxt = {1'b0, knob_step} + 9'd1;
            endcase
          end
        end
        CMD_BUTTON: begin
          case (phase_r)
            PH_SETUP: begin
              if (sdn_r) begin
                stamp_nxt = tick_r;
                phase_nxt = PH_SELECT;
              end
              if (stdn_r) begin
                leds_nxt   = LEDS_FULL;
                remain_nxt = time_r;
                phase_nxt  = PH_COOK;
              end
            end
            PH_SELECT: begin
              if (sup_r) begin
                if (!press_is_long) begin
                  case (mode_r)
                    MODE_BAKE:  mode_nxt = MODE_BROIL;
                    MODE_BROIL: mode_nxt = MODE_TOAST;
                    default: begin
                      mode_nxt = MODE_BAKE;
                      temp_nxt = {1'b0, bake_temp_r};
                    end
                  endcase
                end else begin
                  adjust_nxt = ~adjust_r;
                end
                phase_nxt = PH_SETUP;
              end
            end
            PH_COOK: begin
              if (stdn_r) begin
                stamp_nxt = tick_r;
                phase_nxt = PH_RESET;
              end
            end
            default: begin
              if (stup_r) begin
                elapsed_nxt = 9'd0;
                if (press_is_long) begin
                  leds_nxt  = 8'd0;
                  phase_nxt = PH_SETUP;
                end else begin
                  leds_nxt   = LEDS_FULL;
                  remain_nxt = time_r;
                  phase_nxt  = PH_COOK;
                end
              end
            end
          endcase
        end
        CMD_TICK: begin
          tick_nxt = tick_r + 16'd1;
          if (sub_inc >= tps_eff) begin
            subtick_nxt = 8'd0;
            if (phase_r == PH_COOK) begin
              if (elapsed_inc >= time_r) begin
                remain_nxt  = time_r;
                elapsed_nxt = 9'd0;
                leds_nxt    = 8'd0;
                phase_nxt   = PH_SETUP;
              end else begin
                elapsed_nxt  = elapsed_inc;
                remain_nxt   = time_r - elapsed_inc;
                need_mod_nxt = 1'b1;
              end
            end
          end else begin
            subtick_nxt = sub_inc;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl.led_apply && (rem_step == 6'd0)) begin
      leds_nxt = {leds_r[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_limit_r <= HOLD_LIMIT_RST;
      tps_r        <= TPS_RST;
      temp_base_r  <= TEMP_BASE_RST;
      bake_temp_r  <= BAKE_TEMP_RST;
      broil_temp_r <= BROIL_TEMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_LIMIT: hold_limit_r <= cfg_data;
        REG_TPS:        tps_r        <= cfg_data[7:0];
        REG_TEMP_BASE:  temp_base_r  <= cfg_data[9:0];
        REG_BAKE_TEMP:  bake_temp_r  <= cfg_data[9:0];
        REG_BROIL_TEMP: broil_temp_r <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= in_cmd;
      knob_r <= in_knob_value;
      sdn_r  <= in_select_pressed;
      sup_r  <= in_select_released;
      stdn_r <= in_start_pressed;
      stup_r <= in_start_released;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SETUP;
      mode_r     <= MODE_BAKE;
      adjust_r   <= 1'b0;
      time_r     <= 9'd1;
      remain_r   <= 9'd0;
      temp_r     <= {1'b0, BAKE_TEMP_RST};
      elapsed_r  <= 9'd0;
      tick_r     <= 16'd0;
      stamp_r    <= 16'd0;
      subtick_r  <= 8'd0;
      leds_r     <= 8'd0;
      need_mod_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      mode_r     <= mode_nxt;
      adjust_r   <= adjust_nxt;
      time_r     <= time_nxt;
      remain_r   <= remain_nxt;
      temp_r     <= temp_nxt;
      elapsed_r  <= elapsed_nxt;
      tick_r     <= tick_nxt;
      stamp_r    <= stamp_nxt;
      subtick_r  <= subtick_nxt;
      leds_r     <= leds_nxt;
      need_mod_r <= need_mod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      rem_r     <= 6'd0;
      bit_idx_r <= MOD_TOP_BIT;
    end else if (ctl.mod_step) begin
      rem_r     <= rem_step;
      bit_idx_r <= bit_idx_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_phase_r  <= phase_r;
      out_mode_r   <= mode_r;
      out_adjust_r <= adjust_r;
      out_time_r   <= time_r;
      out_remain_r <= remain_r;
      out_temp_r   <= temp_r;
      out_leds_r   <= leds_r;
    end
  end

  assign sts.need_mod = need_mod_r;
  assign sts.mod_last = (bit_idx_r == 4'd0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_phase       = out_phase_r;
  assign out_cook_mode   = out_mode_r;
  assign out_adjust_temp = out_adjust_r;
  assign out_set_time    = out_time_r;
  assign out_remaining   = out_remain_r;
  assign out_temperature = out_temp_r;
  assign out_led_bar     = out_leds_r;

endmodule

>>> hdl/oven_controller_fsm.sv
// Oven controller top level: sequencer plus datapath behind two channels.
// Depends on ovc_pkg, ovc_if, ovc_ctrl and ovc_datapath.
//
//  channel  direction  beat
//  in_ch    sink       one oven event (knob, button edges or fast tick)
//  out_ch   source     oven status after that event
//  cfg_*    write      register index and data, no handshake
//
// An event is latched on accept, executed, then loaded into the result register;
// a second tick while cooking first runs the 9-step bar-segment remainder unit.
// The next event is accepted while a result waits in the output register.
// A stalled out_ch holds the sequencer before its output load.
// Reset is synchronous, active low; no clearing pass.
module oven_controller_fsm
  import ovc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  ovc_evt_if.sink             in_ch,
  ovc_res_if.source           out_ch
);

  ovc_ctl_t ctl;
  ovc_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  ovc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ovc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (in_ch.cmd),
    .in_knob_value      (in_ch.knob_value),
    .in_select_pressed  (in_ch.select_pressed),
    .in_select_released (in_ch.select_released),
    .in_start_pressed   (in_ch.start_pressed),
    .in_start_released  (in_ch.start_released),
    .ctl                (ctl),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_phase          (out_ch.phase),
    .out_cook_mode      (out_ch.cook_mode),
    .out_adjust_temp    (out_ch.adjust_temp),
    .out_set_time       (out_ch.set_time),
    .out_remaining      (out_ch.remaining),
    .out_temperature    (out_ch.temperature),
    .out_led_bar        (out_ch.led_bar)
  );

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> ctl.exec)
    else $error("accepted beat not executed");
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mod_step |-> !in_ch.ready)
    else $error("input ready during remainder steps");
  a_apply_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.led_apply |-> (ctl.mod_step && sts.mod_last))
    else $error("bar shift outside last remainder step");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_ch.valid)
    else $error("output load lost");
`endif

endmodule
